/* rtl/core/shlex_pkg.sv */
// ----------------------------------------------------------------------------
// shlex_pkg
// Shared types and codes for the shell script lexer.
// ----------------------------------------------------------------------------
package shlex_pkg;

  localparam int MAX_SOURCE_DEF = 65536;
  localparam int FIFO_DEPTH     = 4;

  // token kinds
  localparam logic [3:0] K_SEP       = 4'd0;
  localparam logic [3:0] K_OPEN      = 4'd1;
  localparam logic [3:0] K_CLOSE     = 4'd2;
  localparam logic [3:0] K_SIGIL     = 4'd3;
  localparam logic [3:0] K_SYMBOL    = 4'd4;
  localparam logic [3:0] K_INT       = 4'd5;
  localparam logic [3:0] K_DO        = 4'd6;
  localparam logic [3:0] K_END       = 4'd7;
  localparam logic [3:0] K_EOS       = 4'd8;
  localparam logic [3:0] K_BAD_FLOAT = 4'd9;

  localparam logic [62:0] VAL_MAX = {63{1'b1}};

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [62:0] value;
  } token_t;

  // tokens produced by one byte, in order
  typedef struct packed {
    logic [1:0] n;
    token_t     a;
    token_t     b;
  } push_t;

  typedef struct packed {
    token_t tok;
    logic   last;
  } entry_t;

endpackage

/* rtl/core/shell_script_lexer_top.sv */
// ----------------------------------------------------------------------------
// shell_script_lexer_top
// Streaming lexer for a small shell-like script language.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, src_byte) takes one source byte per
//   item; a zero byte ends the source. Output channel (out_valid/out_ready)
//   gives one token per item: tok_kind, tok_start, tok_len, int_value, and
//   run_last, set on the last token caused by a byte.
//   Rate: one byte per cycle while the queue has room. A byte is held in the
//   input register, is lexed there, and its tokens land in a 4-entry output
//   queue, from which the first token is shown on the output. Bytes giving two
//   tokens (a pending int or symbol closed by a special byte, newline or
//   zero byte, or a string closed by the zero byte) leave an extra token to
//   drain; input keeps flowing while the queue has room for two.
//   Stall: when the receiver holds out_ready low the queue fills and
//   in_ready drops once fewer than two slots are free; nothing is lost.
//   Reset: rst (synchronous) empties the queue and input register and puts
//   the lexer in idle at offset 0. After the end-of-stream token further
//   bytes are accepted and dropped until the next reset.
// ----------------------------------------------------------------------------
module shell_script_lexer_top import shlex_pkg::*; #(
  parameter int MAX_SOURCE = MAX_SOURCE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  src_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  tok_kind,
  output logic [15:0] tok_start,
  output logic [15:0] tok_len,
  output logic [62:0] int_value,
  output logic        run_last
);

  // input register
  logic       in_full;
  logic [7:0] byte_q;
  logic       fire;
  logic       room;
  logic       pop;
  push_t      push;
  entry_t     head;
  logic [$clog2(FIFO_DEPTH):0] level;

  // lex the held byte only when the queue can take both possible tokens
  assign fire     = in_full && room;
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) byte_q <= src_byte;
  end

  shlex_core #(.MAX_SOURCE(MAX_SOURCE)) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .src_byte (byte_q),
    .push     (push)
  );

  shlex_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .room  (room),
    .level (level)
  );

  assign out_valid = level != '0;
  assign pop       = out_valid && out_ready;
  assign tok_kind  = head.tok.kind;
  assign tok_start = head.tok.start;
  assign tok_len   = head.tok.len;
  assign int_value = head.tok.value;
  assign run_last  = head.last;

  logic eos_pushed;
  assign eos_pushed = (push.n == 2'd1 && push.a.kind == K_EOS) ||
                      (push.n == 2'd2 && push.b.kind == K_EOS);

`ifndef ASSERT_OFF
  // queue never overfills
  a_level: assert property (@(posedge clk) disable iff (rst)
    level <= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH))
    else $error("token queue overflow");

  // only a closing int/symbol/keyword token can precede a second token
  a_pair: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> (push.a.kind == K_INT || push.a.kind == K_SYMBOL ||
                        push.a.kind == K_DO || push.a.kind == K_END))
    else $error("bad token pair");

  // nothing follows end of stream
  a_eos: assert property (@(posedge clk) disable iff (rst)
    eos_pushed |=> push.n == 2'd0)
    else $error("token after end of stream");

  // tokens are only formed for a lexed byte
  a_fire: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> fire)
    else $error("token without byte");
`endif

endmodule

/* rtl/core/shlex_core.sv */
// ----------------------------------------------------------------------------
// shlex_core
// Lexer mode machine: consumes one byte per fire, forms up to two tokens.
// ----------------------------------------------------------------------------
module shlex_core import shlex_pkg::*; #(
  parameter int MAX_SOURCE = MAX_SOURCE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] src_byte,
  output push_t      push
);

  localparam int PW = $clog2(MAX_SOURCE);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_NLSKIP  = 3'd1;
  localparam logic [2:0] M_COMMENT = 3'd2;
  localparam logic [2:0] M_STRING  = 3'd3;
  localparam logic [2:0] M_NUMBER  = 3'd4;
  localparam logic [2:0] M_SYMBOL  = 3'd5;

  localparam logic [PW:0]  MAX_W     = (PW+1)'(MAX_SOURCE);
  localparam logic [23:0]  PFX_DO    = 24'h006f64;
  localparam logic [23:0]  PFX_END   = 24'h646e65;

  logic [2:0]    lex_mode, lex_mode_next;
  logic [PW-1:0] byte_pos, byte_pos_next;
  logic [PW-1:0] token_begin, token_begin_next;
  logic [62:0]   num_accum, num_accum_next;
  logic [23:0]   sym_prefix, sym_prefix_next;
  logic [2:0]    sym_count, sym_count_next;
  logic          stream_done, stream_done_next;

  logic          fresh, mt_v, ft_v;
  token_t        mt, ft;
  logic          is_ws, is_digit, spec_v;
  logic [3:0]    spec_kind, sym_kind;
  logic [66:0]   acc_wide;
  logic [PW:0]   pos_inc;
  logic [15:0]   cur_len;

  function automatic logic [15:0] span16(input logic [PW-1:0] from,
                                         input logic [PW-1:0] to);
    logic [PW:0] d;
    if (to >= from) d = {1'b0, to} - {1'b0, from};
    else            d = {1'b0, to} + MAX_W - {1'b0, from};
    return 16'(d);
  endfunction

  always_comb begin
    is_ws    = (src_byte == 8'h20) || (src_byte == 8'h09) ||
               (src_byte == 8'h0a) || (src_byte == 8'h0d);
    is_digit = (src_byte >= 8'h30) && (src_byte <= 8'h39);
    spec_v    = 1'b1;
    spec_kind = K_SEP;
    unique case (src_byte)
      8'h2c:        spec_kind = K_SEP;
      8'h28, 8'h5b: spec_kind = K_OPEN;
      8'h29, 8'h5d: spec_kind = K_CLOSE;
      8'h27, 8'h24, 8'h40: spec_kind = K_SIGIL;
      default:      spec_v = 1'b0;
    endcase
    // accum * 10 + digit, saturating at 2^63-1
    acc_wide = ({4'd0, num_accum} << 3) + ({4'd0, num_accum} << 1)
             + {63'd0, src_byte[3:0]};
    pos_inc  = {1'b0, byte_pos} + (PW+1)'(1);
    cur_len  = span16(token_begin, byte_pos);
    if (sym_count == 3'd2 && sym_prefix == PFX_DO)       sym_kind = K_DO;
    else if (sym_count == 3'd3 && sym_prefix == PFX_END) sym_kind = K_END;
    else                                                 sym_kind = K_SYMBOL;
  end

  always_comb begin
    lex_mode_next    = lex_mode;
    byte_pos_next    = (pos_inc >= MAX_W) ? '0 : pos_inc[PW-1:0];
    token_begin_next = token_begin;
    num_accum_next   = num_accum;
    sym_prefix_next  = sym_prefix;
    sym_count_next   = sym_count;
    stream_done_next = stream_done;
    fresh = 1'b0;
    mt_v  = 1'b0;
    ft_v  = 1'b0;
    mt    = '0;
    ft    = '0;

    // pending token of the current mode
    unique case (lex_mode)
      M_NUMBER: begin
        mt.start = 16'(token_begin);
        mt.len   = cur_len;
        mt.value = num_accum;
        if (is_digit) begin
          num_accum_next = (acc_wide[66:63] != 4'd0) ? VAL_MAX : acc_wide[62:0];
        end else if (src_byte == 8'h2e) begin
          mt_v          = 1'b1;
          mt.kind       = K_BAD_FLOAT;
          lex_mode_next = M_IDLE;
        end else begin
          mt_v    = 1'b1;
          mt.kind = K_INT;
          fresh   = 1'b1;
        end
      end
      M_SYMBOL: begin
        if (src_byte != 8'd0 && !is_ws && !spec_v) begin
          unique case (sym_count)
            3'd0:    sym_prefix_next[7:0]   = src_byte;
            3'd1:    sym_prefix_next[15:8]  = src_byte;
            3'd2:    sym_prefix_next[23:16] = src_byte;
            default: sym_prefix_next = sym_prefix;
          endcase
          if (sym_count < 3'd4) sym_count_next = sym_count + 3'd1;
        end else begin
          mt_v     = 1'b1;
          mt.kind  = sym_kind;
          mt.start = 16'(token_begin);
          mt.len   = cur_len;
          fresh    = 1'b1;
        end
      end
      M_STRING: begin
        mt.kind  = K_SYMBOL;
        mt.start = 16'(token_begin);
        mt.len   = cur_len;
        if (src_byte == 8'h22) begin
          mt_v          = 1'b1;
          lex_mode_next = M_IDLE;
        end else if (src_byte == 8'd0) begin
          mt_v  = 1'b1;
          fresh = 1'b1;
        end
      end
      M_COMMENT: begin
        if (src_byte == 8'h23) lex_mode_next = M_IDLE;
        else if (src_byte == 8'h0a || src_byte == 8'd0) fresh = 1'b1;
      end
      M_NLSKIP: begin
        if (src_byte == 8'd0 || !is_ws) fresh = 1'b1;
      end
      default: fresh = 1'b1;
    endcase

    // byte lexed from idle
    if (fresh) begin
      lex_mode_next = M_IDLE;
      ft.start      = 16'(byte_pos);
      ft.len        = 16'd1;
      priority if (src_byte == 8'd0) begin
        ft_v             = 1'b1;
        ft.kind          = K_EOS;
        ft.len           = 16'd0;
        stream_done_next = 1'b1;
      end else if (src_byte == 8'h0a) begin
        ft_v          = 1'b1;
        ft.kind       = K_SEP;
        lex_mode_next = M_NLSKIP;
      end else if (is_ws) begin
        ft_v = 1'b0;
      end else if (src_byte == 8'h23) begin
        lex_mode_next = M_COMMENT;
      end else if (spec_v) begin
        ft_v    = 1'b1;
        ft.kind = spec_kind;
      end else if (src_byte == 8'h22) begin
        lex_mode_next    = M_STRING;
        token_begin_next = byte_pos_next;
      end else if (is_digit) begin
        lex_mode_next    = M_NUMBER;
        token_begin_next = byte_pos;
        num_accum_next   = {59'd0, src_byte[3:0]};
      end else begin
        lex_mode_next    = M_SYMBOL;
        token_begin_next = byte_pos;
        sym_prefix_next  = {16'd0, src_byte};
        sym_count_next   = 3'd1;
      end
    end

    push.a = mt_v ? mt : ft;
    push.b = ft;
    push.n = (fire && !stream_done) ? ({1'b0, mt_v} + {1'b0, ft_v}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode    <= M_IDLE;
      byte_pos    <= '0;
      token_begin <= '0;
      num_accum   <= '0;
      sym_prefix  <= '0;
      sym_count   <= '0;
      stream_done <= 1'b0;
    end else if (fire && !stream_done) begin
      lex_mode    <= lex_mode_next;
      byte_pos    <= byte_pos_next;
      token_begin <= token_begin_next;
      num_accum   <= num_accum_next;
      sym_prefix  <= sym_prefix_next;
      sym_count   <= sym_count_next;
      stream_done <= stream_done_next;
    end
  end

endmodule

/* rtl/core/shlex_fifo.sv */
// ----------------------------------------------------------------------------
// shlex_fifo
// Small token queue: takes up to two tokens a cycle, gives one.
// ----------------------------------------------------------------------------
module shlex_fifo import shlex_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  input  logic   pop,
  output entry_t head,
  output logic   room,
  output logic [$clog2(FIFO_DEPTH):0] level
);

  localparam int AW = $clog2(FIFO_DEPTH);

  entry_t        mem [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= '{tok: push.a, last: (push.n == 2'd1)};
    if (push.n == 2'd2) mem[wr_ptr + AW'(1)] <= '{tok: push.b, last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.n);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      count  <= count + (AW+1)'(push.n) - (AW+1)'(pop);
    end
  end

  assign head  = mem[rd_ptr];
  assign room  = count <= (AW+1)'(FIFO_DEPTH - 2);
  assign level = count;

endmodule

/* sim/tb_shell_script_lexer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_script_lexer_top
// Self-checking bench for the streaming shell script lexer.
// ----------------------------------------------------------------------------
// One source is fed through the byte channel: a short table of hand-picked
// bytes first, then random token fragments. A zero byte closes the source,
// followed by a few bytes that must be dropped.
// Every accepted byte runs through a local
// tokenizer model; each token leaving the block is compared field by field
// with the oldest predicted token. Both channels idle at random, with one
// calm stretch and one long receiver hold-off that backs up the input side.
// ----------------------------------------------------------------------------
module tb_shell_script_lexer_top;
  import shlex_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no accept before giving up
  localparam int RANDOM_ITEMS = 1220;
  localparam int SQUEEZE_AT = 300;    // random item count that starts the hold-off
  localparam int SQUEEZE_LEN = 80;
  localparam int CALM_FROM = 800;
  localparam int CALM_TO = 950;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_DOT = 8'h2E;

  // lexer modes of the local model
  typedef enum logic [2:0] {
    LM_IDLE, LM_NLSKIP, LM_COMMENT, LM_STRING, LM_NUMBER, LM_SYMBOL
  } lex_mode_e;

  typedef struct {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [62:0] value;
    logic        last;
  } tok_rec_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;  // tok holds a hand-written expectation
    tok_rec_t   tok;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  src_byte;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  tok_kind;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [62:0] int_value;
  logic        run_last;

  shell_script_lexer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src_byte  (src_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tok_kind  (tok_kind),
    .tok_start (tok_start),
    .tok_len   (tok_len),
    .int_value (int_value),
    .run_last  (run_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tokenizer model state. Offsets are 16 bits wide, so they wrap at 64K,
  // which matches the block's default source size.
  // --------------------------------------------------------------------------
  lex_mode_e   lx_mode;
  logic [15:0] lx_pos;
  logic [15:0] lx_begin;
  longint unsigned lx_acc;
  logic [23:0] lx_pfx;     // first three symbol bytes
  int          lx_cnt;     // symbol length, saturates at 4
  bit          lx_done;

  tok_rec_t step_toks[$];       // tokens of the byte being modeled
  tok_rec_t pending_tokens[$];  // tokens still owed by the block
  dir_row_t dir_rows[$];
  logic [7:0] frag[$];

  int  mismatches;
  int  tok_seen;
  int  rnd_cnt;
  bit  calm;      // no idling on either side
  bit  holding;   // receiver hold-off in progress
  bit  squeezed;
  bit  row_typed;
  tok_rec_t row_tok;

  function automatic bit is_ws(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_NL || c == CH_CR;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_special(logic [7:0] c);
    return c == "," || c == "(" || c == "[" || c == ")" || c == "]" ||
           c == "'" || c == "$" || c == "@";
  endfunction

  function automatic logic [3:0] special_kind(logic [7:0] c);
    case (c)
      ",": return K_SEP;
      "(", "[": return K_OPEN;
      ")", "]": return K_CLOSE;
      default: return K_SIGIL;
    endcase
  endfunction

  function automatic void add_tok(logic [3:0] k, logic [15:0] s, logic [15:0] l,
                                  longint unsigned v);
    step_toks.push_back('{k, s, l, v[62:0], 1'b0});
  endfunction

  task automatic reset_model();
    lx_mode = LM_IDLE;
    lx_pos = '0;
    lx_begin = '0;
    lx_acc = 0;
    lx_pfx = '0;
    lx_cnt = 0;
    lx_done = 1'b0;
  endtask

  // Work out the tokens that one source byte gives, into step_toks.
  task automatic tokenize_byte(input logic [7:0] b);
    longint unsigned vmax;
    longint unsigned d;
    bit fresh;
    logic [3:0] kw;
    vmax = {1'b0, VAL_MAX};
    fresh = 1'b0;
    step_toks.delete();
    if (!lx_done) begin
      case (lx_mode)
        LM_NUMBER: begin
          if (is_digit(b)) begin
            d = 64'(b - 8'h30);
            if (lx_acc > (vmax - d) / 10) lx_acc = vmax;
            else lx_acc = lx_acc * 10 + d;
          end else if (b == CH_DOT) begin
            add_tok(K_BAD_FLOAT, lx_begin, lx_pos - lx_begin, lx_acc);
            lx_mode = LM_IDLE;
          end else begin
            add_tok(K_INT, lx_begin, lx_pos - lx_begin, lx_acc);
            lx_mode = LM_IDLE;
            fresh = 1'b1;
          end
        end
        LM_SYMBOL: begin
          if (b != CH_NUL && !is_ws(b) && !is_special(b)) begin
            if (lx_cnt < 3) lx_pfx[8*lx_cnt +: 8] = b;
            if (lx_cnt < 4) lx_cnt++;
          end else begin
            kw = K_SYMBOL;
            if (lx_cnt == 2 && lx_pfx == {8'h00, "o", "d"}) kw = K_DO;
            else if (lx_cnt == 3 && lx_pfx == {"d", "n", "e"}) kw = K_END;
            add_tok(kw, lx_begin, lx_pos - lx_begin, 0);
            lx_mode = LM_IDLE;
            fresh = 1'b1;
          end
        end
        LM_STRING: begin
          if (b == CH_QUOTE || b == CH_NUL) begin
            add_tok(K_SYMBOL, lx_begin, lx_pos - lx_begin, 0);
            lx_mode = LM_IDLE;
            fresh = (b == CH_NUL);
          end
        end
        LM_COMMENT: begin
          if (b == CH_HASH) begin
            lx_mode = LM_IDLE;
          end else if (b == CH_NL || b == CH_NUL) begin
            lx_mode = LM_IDLE;
            fresh = 1'b1;
          end
        end
        LM_NLSKIP: begin
          if (b == CH_NUL || !is_ws(b)) begin
            lx_mode = LM_IDLE;
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase

      // byte lexed from scratch
      if (fresh) begin
        if (b == CH_NUL) begin
          add_tok(K_EOS, lx_pos, 16'd0, 0);
          lx_done = 1'b1;
        end else if (b == CH_NL) begin
          add_tok(K_SEP, lx_pos, 16'd1, 0);
          lx_mode = LM_NLSKIP;
        end else if (is_ws(b)) begin
          // skipped
        end else if (b == CH_HASH) begin
          lx_mode = LM_COMMENT;
        end else if (is_special(b)) begin
          add_tok(special_kind(b), lx_pos, 16'd1, 0);
        end else if (b == CH_QUOTE) begin
          lx_mode = LM_STRING;
          lx_begin = lx_pos + 16'd1;
        end else if (is_digit(b)) begin
          lx_mode = LM_NUMBER;
          lx_begin = lx_pos;
          lx_acc = 64'(b - 8'h30);
        end else begin
          lx_mode = LM_SYMBOL;
          lx_begin = lx_pos;
          lx_pfx = {16'h0000, b};
          lx_cnt = 1;
        end
      end
      lx_pos = lx_pos + 16'd1;
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    end
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch: token %0d %s got %0h want %0h", tok_seen, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: model each accepted byte, check each accepted token.
  // Inputs only move at the falling edge, so sampling here is race free.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        tokenize_byte(src_byte);
        if (row_typed) begin
          step_toks.delete();
          step_toks.push_back(row_tok);
        end
        foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
      end
      if (out_valid && out_ready) begin
        if (pending_tokens.size() == 0) begin
          flag_mismatch("unexpected, kind", 64'(tok_kind), 0);
        end else begin
          row_tok_check : begin
            tok_rec_t w;
            w = pending_tokens.pop_front();
            if (tok_kind !== w.kind)
              flag_mismatch("tok_kind", 64'(tok_kind), 64'(w.kind));
            if (tok_start !== w.start)
              flag_mismatch("tok_start", 64'(tok_start), 64'(w.start));
            if (tok_len !== w.len)
              flag_mismatch("tok_len", 64'(tok_len), 64'(w.len));
            if (int_value !== w.value)
              flag_mismatch("int_value", 64'(int_value), 64'(w.value));
            if (run_last !== w.last)
              flag_mismatch("run_last", 64'(run_last), 64'(w.last));
          end
        end
        tok_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with nothing accepted on either channel ends the run.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Token receiver: random ready, plus one long hold-off while the sender
  // keeps pushing, so the output queue fills and in_ready drops.
  // --------------------------------------------------------------------------
  initial begin : token_sink
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (!squeezed && rnd_cnt >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        holding = 1'b1;
        out_ready <= 1'b0;
        repeat (SQUEEZE_LEN) @(negedge clk);
        holding = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  // Offer one byte, idling at random first; returns at the falling edge
  // after the byte was taken.
  task automatic send_byte(input logic [7:0] b, input bit typed, input tok_rec_t t);
    while (!(calm || holding) && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    src_byte <= b;
    row_typed = typed;
    row_tok = t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic add_plain(input logic [7:0] b);
    dir_rows.push_back('{b, 1'b0, '{4'd0, 16'd0, 16'd0, 63'd0, 1'b0}});
  endtask

  task automatic add_typed(input logic [7:0] b, input logic [3:0] k,
                           input logic [15:0] s, input logic [15:0] l,
                           input logic [62:0] v);
    dir_rows.push_back('{b, 1'b1, '{k, s, l, v, 1'b1}});
  endtask

  function automatic logic [7:0] any_but(logic [7:0] x, logic [7:0] y);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == x || c == y);
    return c;
  endfunction

  function automatic logic [7:0] sym_byte(bit first);
    logic [7:0] c;
    if (first && $urandom_range(1)) return 8'("a" + $urandom_range(25));
    do c = 8'($urandom_range(1, 255));
    while (is_ws(c) || is_special(c) ||
           (first && (c == CH_HASH || c == CH_QUOTE || is_digit(c))));
    return c;
  endfunction

  task automatic push_digits(input int n);
    for (int i = 0; i < n; i++) frag.push_back(8'("0" + $urandom_range(9)));
  endtask

  task automatic push_symbol();
    string kws[8];
    string s;
    int n;
    kws = '{"do", "end", "d", "en", "dox", "endx", "e", "od"};
    if ($urandom_range(2) == 0) begin
      s = kws[$urandom_range(7)];
      for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
    end else begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) frag.push_back(sym_byte(i == 0));
    end
  endtask

  // One random, mostly well-formed fragment of source into frag.
  task automatic build_fragment();
    string specials;
    int pick;
    int n;
    specials = ",([)]'$@";
    frag.delete();
    pick = $urandom_range(99);
    if (pick < 20) begin
      // integers, sometimes long enough to saturate, sometimes a float
      n = ($urandom_range(9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 6);
      if (n > 17 && $urandom_range(1)) for (int i = 0; i < n; i++) frag.push_back("9");
      else push_digits(n);
      if ($urandom_range(3) == 0) frag.push_back(CH_DOT);
    end else if (pick < 40) begin
      push_symbol();
    end else if (pick < 50) begin
      frag.push_back(CH_QUOTE);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) frag.push_back(any_but(CH_QUOTE, CH_QUOTE));
      frag.push_back(CH_QUOTE);
    end else if (pick < 58) begin
      frag.push_back(CH_HASH);
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) frag.push_back(any_but(CH_HASH, CH_NL));
      frag.push_back($urandom_range(1) ? CH_HASH : CH_NL);
    end else if (pick < 78) begin
      frag.push_back(specials[$urandom_range(7)]);
    end else if (pick < 90) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(3))
          0: frag.push_back(CH_SP);
          1: frag.push_back(CH_TAB);
          2: frag.push_back(CH_CR);
          default: frag.push_back(CH_NL);
        endcase
      end
    end else begin
      frag.push_back(8'($urandom_range(1, 255)));
    end
    // half the time run straight into the next fragment
    if ($urandom_range(1)) frag.push_back($urandom_range(3) == 0 ? CH_NL : CH_SP);
  endtask

  // --------------------------------------------------------------------------
  // Main stimulus
  // --------------------------------------------------------------------------
  initial begin : main
    tok_rec_t none;
    none = '{4'd0, 16'd0, 16'd0, 63'd0, 1'b0};
    rst = 1'b1;
    in_valid = 1'b0;
    src_byte = '0;
    row_typed = 1'b0;
    row_tok = none;
    mismatches = 0;
    tok_seen = 0;
    rnd_cnt = 0;
    calm = 1'b0;
    holding = 1'b0;
    squeezed = 1'b0;
    reset_model();

    // Directed source, offsets from 0:
    // "(9.[ do)\n\r\tend,#x#$\"a\"#\n42]"
    add_typed("(", K_OPEN, 16'd0, 16'd1, 63'd0);
    add_plain("9");
    add_typed(CH_DOT, K_BAD_FLOAT, 16'd1, 16'd1, 63'd9);  // digits then dot
    add_typed("[", K_OPEN, 16'd3, 16'd1, 63'd0);
    add_plain(CH_SP);
    add_plain("d");
    add_plain("o");
    add_plain(")");                                        // do, then close
    add_typed(CH_NL, K_SEP, 16'd8, 16'd1, 63'd0);
    add_plain(CH_CR);                                      // newline run swallows these
    add_plain(CH_TAB);
    add_plain("e");
    add_plain("n");
    add_plain("d");
    add_plain(",");                                        // end, then separator
    add_plain(CH_HASH);                                    // comment closed by '#'
    add_plain("x");
    add_plain(CH_HASH);
    add_typed("$", K_SIGIL, 16'd18, 16'd1, 63'd0);
    add_plain(CH_QUOTE);
    add_plain("a");
    add_plain(CH_QUOTE);
    add_plain(CH_HASH);                                    // comment closed by newline
    add_typed(CH_NL, K_SEP, 16'd23, 16'd1, 63'd0);
    add_plain("4");
    add_plain("2");
    add_plain("]");                                        // int 42, then close

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].tok);
    end

    // random fragments
    while (rnd_cnt < RANDOM_ITEMS) begin
      calm = (rnd_cnt >= CALM_FROM && rnd_cnt < CALM_TO);
      build_fragment();
      foreach (frag[i]) begin
        send_byte(frag[i], 1'b0, none);
        rnd_cnt++;
      end
    end
    calm = 1'b0;

    // close the source with something pending: nothing, an int, a symbol
    // or an unterminated string
    frag.delete();
    case ($urandom_range(3))
      0: frag.push_back(CH_SP);
      1: push_digits($urandom_range(1, 4));
      2: push_symbol();
      default: begin
        frag.push_back(CH_QUOTE);
        frag.push_back("z");
      end
    endcase
    frag.push_back(CH_NUL);
    // bytes after the end of source are taken and dropped
    repeat (4) frag.push_back(8'($urandom_range(255)));
    foreach (frag[i]) send_byte(frag[i], 1'b0, none);
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
